/* src/gsps_pkg.sv */
`timescale 1ns / 1ps

package gsps_pkg;

    localparam int FRAC_BITS_DEF = 4;

    // field and state widths
    localparam int DIST_W  = 15;
    localparam int BAND_W  = 3;
    localparam int SERVO_W = 15;
    localparam int SPEED_W = 4;
    localparam int LIMIT_W = 2;
    localparam int GAIN_W  = 4;
    localparam int ERR_W   = 18;
    localparam int TURN_W  = 32;
    localparam int TDATA_W = 24;

    localparam logic [BAND_W-1:0] BAND_MAX = 3'd4;

    localparam logic signed [ERR_W-1:0] ERR_MAX = 18'sh1FFFF;
    localparam logic signed [ERR_W-1:0] ERR_MIN = -18'sh20000;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;
    localparam int CREF_W     = 11;
    localparam int SWING_W    = 12;

    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_REF   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SERVO_CENTER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SERVO_SWING  = 2'd2;

    localparam logic [SERVO_W-1:0] SERVO_CENTER_RST = 15'd2870;
    localparam logic [SWING_W-1:0] SERVO_SWING_RST  = 12'd725;

    // limit codes
    localparam logic [LIMIT_W-1:0] LIM_NONE = 2'd0;
    localparam logic [LIMIT_W-1:0] LIM_HIGH = 2'd1;
    localparam logic [LIMIT_W-1:0] LIM_LOW  = 2'd2;

    // multiplier operand select
    localparam logic [1:0] MUL_E0 = 2'd0;
    localparam logic [1:0] MUL_E1 = 2'd1;
    localparam logic [1:0] MUL_E2 = 2'd2;

    // serial divider: 3 quotient bits per step, 36-bit dividend
    localparam int DIV_BITS  = 3;
    localparam int DIV_STEPS = 12;
    localparam int DIVN_W    = DIV_BITS * DIV_STEPS;
    localparam int DEN_W     = 7;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // gain schedule, indexed [position band][speed band]
    localparam logic [GAIN_W-1:0] GAIN_P [5][5] = '{
        '{4'd12, 4'd10, 4'd9, 4'd10, 4'd12},
        '{4'd10, 4'd9,  4'd8, 4'd9,  4'd10},
        '{4'd7,  4'd7,  4'd7, 4'd7,  4'd7},
        '{4'd9,  4'd7,  4'd5, 4'd7,  4'd9},
        '{4'd5,  4'd4,  4'd3, 4'd4,  4'd5}};

    localparam logic [GAIN_W-1:0] GAIN_D [5][5] = '{
        '{4'd2,  4'd4,  4'd7, 4'd4,  4'd2},
        '{4'd4,  4'd5,  4'd6, 4'd5,  4'd4},
        '{4'd6,  4'd7,  4'd8, 4'd7,  4'd6},
        '{4'd9,  4'd7,  4'd8, 4'd7,  4'd9},
        '{4'd12, 4'd10, 4'd9, 4'd10, 4'd12}};

    localparam logic [SPEED_W-1:0] SPEED_TAB [5][5] = '{
        '{4'd6, 4'd7, 4'd9, 4'd7, 4'd6},
        '{4'd4, 4'd6, 4'd9, 4'd6, 4'd4},
        '{4'd3, 4'd5, 4'd9, 4'd5, 4'd3},
        '{4'd2, 4'd4, 4'd9, 4'd4, 4'd2},
        '{4'd1, 4'd3, 4'd9, 4'd3, 4'd1}};

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       sum;
        logic       scale;
        logic       div_step;
        logic       finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_sts;

endpackage

/* src/gsps_ctrl.sv */
`timescale 1ns / 1ps

module gsps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gsps_pkg::t_dp_sts i_sts,
    output gsps_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL0  = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    localparam logic [gsps_pkg::CNT_W-1:0] CNT_LAST =
        gsps_pkg::CNT_W'(gsps_pkg::DIV_STEPS - 1);

    logic [2:0]                  r_state, n_state;
    logic [gsps_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = gsps_pkg::MUL_E0;
                n_state       = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = gsps_pkg::MUL_E1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = gsps_pkg::MUL_E2;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_cnt       = '0;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register can take the result
                if (!i_sts.out_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* src/gsps_datapath.sv */
`timescale 1ns / 1ps

module gsps_datapath #(
    parameter int FRAC_BITS = gsps_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [gsps_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [gsps_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [gsps_pkg::DIST_W-1:0]     i_dist,
    input  logic [gsps_pkg::BAND_W-1:0]            i_pos,
    input  logic [gsps_pkg::BAND_W-1:0]            i_spd,
    input  gsps_pkg::t_dp_cmd                      i_cmd,
    output gsps_pkg::t_dp_sts                      o_sts,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic [gsps_pkg::SERVO_W-1:0]           o_servo,
    output logic [gsps_pkg::SPEED_W-1:0]           o_speed,
    output logic [gsps_pkg::LIMIT_W-1:0]           o_limit
);

    localparam int ERR_W   = gsps_pkg::ERR_W;
    localparam int TURN_W  = gsps_pkg::TURN_W;
    localparam int SCALED_W = gsps_pkg::CREF_W + FRAC_BITS;
    localparam int DIFF_W  = ((SCALED_W > gsps_pkg::DIST_W) ? SCALED_W : gsps_pkg::DIST_W) + 1;
    localparam int CMP_W   = (DIFF_W > ERR_W) ? DIFF_W : ERR_W;
    localparam int COEF_W  = 7;
    localparam int PROD_W  = COEF_W + ERR_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int T7_W    = TURN_W + 3;
    localparam int DIVN_W  = gsps_pkg::DIVN_W;
    localparam int DEN_W   = gsps_pkg::DEN_W;
    localparam int REM_W   = DEN_W + 1;
    localparam int SUMS_W  = TURN_W + 2;
    localparam int SERVO_W = gsps_pkg::SERVO_W;

    localparam logic [ACC_W-1:0] ROUND_MASK = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
    localparam logic [SERVO_W-1:0] SERVO_MAX = {SERVO_W{1'b1}};

    // configuration
    logic signed [gsps_pkg::CREF_W-1:0]  r_center_ref;
    logic [SERVO_W-1:0]                  r_servo_center;
    logic [gsps_pkg::SWING_W-1:0]        r_servo_swing;

    // controller state and per-item operands
    logic signed [TURN_W-1:0]            r_prev;
    logic signed [ERR_W-1:0]             r_e0, r_e1, r_e2;
    logic [gsps_pkg::GAIN_W-1:0]         r_p, r_d;
    logic [gsps_pkg::SPEED_W-1:0]        r_speed;
    logic signed [ACC_W-1:0]             r_acc;
    logic signed [TURN_W-1:0]            r_turn;
    logic                                r_neg;
    logic [DIVN_W-1:0]                   r_num;
    logic [REM_W-1:0]                    r_rem;
    logic [DEN_W-1:0]                    r_den;

    // output register
    logic                                r_out_valid;
    logic [SERVO_W-1:0]                  r_servo;
    logic [gsps_pkg::SPEED_W-1:0]        r_out_speed;
    logic [gsps_pkg::LIMIT_W-1:0]        r_limit;

    // error term
    logic [gsps_pkg::BAND_W-1:0]         w_pos, w_spd;
    logic signed [DIFF_W-1:0]            w_diff;
    logic signed [CMP_W-1:0]             w_diff_x;
    logic signed [ERR_W-1:0]             w_e0;

    always_comb begin
        w_pos    = (i_pos > gsps_pkg::BAND_MAX) ? gsps_pkg::BAND_MAX : i_pos;
        w_spd    = (i_spd > gsps_pkg::BAND_MAX) ? gsps_pkg::BAND_MAX : i_spd;
        w_diff   = (DIFF_W'(r_center_ref) <<< FRAC_BITS) - DIFF_W'(i_dist);
        w_diff_x = CMP_W'(w_diff);
        if (w_diff_x > CMP_W'(gsps_pkg::ERR_MAX)) begin
            w_e0 = gsps_pkg::ERR_MAX;
        end else if (w_diff_x < CMP_W'(gsps_pkg::ERR_MIN)) begin
            w_e0 = gsps_pkg::ERR_MIN;
        end else begin
            w_e0 = w_diff_x[ERR_W-1:0];
        end
    end

    // shared multiplier for the three velocity-form terms
    logic [COEF_W-1:0]          w_pd, w_p2d;
    logic signed [COEF_W-1:0]   w_coef;
    logic signed [ERR_W-1:0]    w_err;
    logic signed [PROD_W-1:0]   w_prod;

    always_comb begin
        w_pd  = COEF_W'(r_p) + COEF_W'(r_d);
        w_p2d = COEF_W'(r_p) + (COEF_W'(r_d) << 1);
        case (i_cmd.mul_sel)
            gsps_pkg::MUL_E0: begin
                w_coef = $signed(w_pd);
                w_err  = r_e0;
            end
            gsps_pkg::MUL_E1: begin
                w_coef = -$signed(w_p2d);
                w_err  = r_e1;
            end
            gsps_pkg::MUL_E2: begin
                w_coef = $signed(COEF_W'(r_d));
                w_err  = r_e2;
            end
            default: begin
                w_coef = '0;
                w_err  = '0;
            end
        endcase
        w_prod = w_coef * w_err;
    end

    // increment with truncation toward zero, then saturating accumulate
    logic signed [ACC_W-1:0]    w_acc_adj, w_inc;
    logic signed [TURN_W:0]     w_sum;

    always_comb begin
        w_acc_adj = r_acc + (r_acc[ACC_W-1] ? $signed(ROUND_MASK) : '0);
        w_inc     = w_acc_adj >>> FRAC_BITS;
        w_sum     = (TURN_W+1)'(r_prev) + (TURN_W+1)'(w_inc);
    end

    // 7*turn and divider setup
    logic signed [T7_W-1:0]     w_t7;
    logic [T7_W-1:0]            w_mag;
    logic [DEN_W-1:0]           w_den;

    always_comb begin
        w_t7  = (T7_W'(r_turn) <<< 3) - T7_W'(r_turn);
        w_mag = w_t7[T7_W-1] ? $unsigned(-w_t7) : $unsigned(w_t7);
        w_den = (DEN_W'(r_p) << 3) + (DEN_W'(r_p) << 1);
    end

    // restoring divide step, several quotient bits per cycle
    logic [REM_W-1:0]           w_rem;
    logic [DIVN_W-1:0]          w_num;

    always_comb begin
        w_rem = r_rem;
        w_num = r_num;
        for (int k = 0; k < gsps_pkg::DIV_BITS; k++) begin
            w_rem = {w_rem[REM_W-2:0], w_num[DIVN_W-1]};
            w_num = {w_num[DIVN_W-2:0], 1'b0};
            if (w_rem >= REM_W'(r_den)) begin
                w_rem    = w_rem - REM_W'(r_den);
                w_num[0] = 1'b1;
            end
        end
    end

    // signed quotient and servo clamp
    logic signed [TURN_W-1:0]   w_q;
    logic signed [SUMS_W-1:0]   w_servo;
    logic [SERVO_W:0]           w_hi_raw;
    logic [SERVO_W-1:0]         w_hi, w_lo;
    logic [SERVO_W-1:0]         w_servo_out;
    logic [gsps_pkg::LIMIT_W-1:0] w_limit;

    always_comb begin
        w_q      = r_neg ? -$signed(r_num[TURN_W-1:0]) : $signed(r_num[TURN_W-1:0]);
        w_servo  = $signed(SUMS_W'(r_servo_center)) + SUMS_W'(w_q);
        w_hi_raw = (SERVO_W+1)'(r_servo_center) + (SERVO_W+1)'(r_servo_swing);
        w_hi     = w_hi_raw[SERVO_W] ? SERVO_MAX : w_hi_raw[SERVO_W-1:0];
        w_lo     = (r_servo_center >= SERVO_W'(r_servo_swing)) ?
                   (r_servo_center - SERVO_W'(r_servo_swing)) : '0;
        if (w_servo > $signed(SUMS_W'(w_hi))) begin
            w_servo_out = w_hi;
            w_limit     = gsps_pkg::LIM_HIGH;
        end else if (w_servo < $signed(SUMS_W'(w_lo))) begin
            w_servo_out = w_lo;
            w_limit     = gsps_pkg::LIM_LOW;
        end else begin
            w_servo_out = w_servo[SERVO_W-1:0];
            w_limit     = gsps_pkg::LIM_NONE;
        end
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_ref   <= '0;
            r_servo_center <= gsps_pkg::SERVO_CENTER_RST;
            r_servo_swing  <= gsps_pkg::SERVO_SWING_RST;
            r_prev         <= '0;
            r_e1           <= '0;
            r_e2           <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    gsps_pkg::CFG_CENTER_REF:   r_center_ref   <= i_cfg_data[gsps_pkg::CREF_W-1:0];
                    gsps_pkg::CFG_SERVO_CENTER: r_servo_center <= i_cfg_data[SERVO_W-1:0];
                    gsps_pkg::CFG_SERVO_SWING:  r_servo_swing  <= i_cfg_data[gsps_pkg::SWING_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_prev      <= w_q;
                r_e2        <= r_e1;
                r_e1        <= r_e0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_e0    <= w_e0;
            r_p     <= gsps_pkg::GAIN_P[w_pos][w_spd];
            r_d     <= gsps_pkg::GAIN_D[w_pos][w_spd];
            r_speed <= gsps_pkg::SPEED_TAB[w_pos][w_spd];
        end
        if (i_cmd.mul_en) begin
            r_acc <= (i_cmd.mul_sel == gsps_pkg::MUL_E0) ? ACC_W'(w_prod)
                                                          : r_acc + ACC_W'(w_prod);
        end
        if (i_cmd.sum) begin
            if (w_sum[TURN_W] != w_sum[TURN_W-1]) begin
                r_turn <= w_sum[TURN_W] ? TURN_MIN : TURN_MAX;
            end else begin
                r_turn <= w_sum[TURN_W-1:0];
            end
        end
        if (i_cmd.scale) begin
            r_neg <= w_t7[T7_W-1];
            r_num <= DIVN_W'(w_mag);
            r_rem <= '0;
            r_den <= w_den;
        end
        if (i_cmd.div_step) begin
            r_num <= w_num;
            r_rem <= w_rem;
        end
        if (i_cmd.finish) begin
            r_servo     <= w_servo_out;
            r_out_speed <= r_speed;
            r_limit     <= w_limit;
        end
    end

    assign o_sts.out_full = r_out_valid & ~i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_servo        = r_servo;
    assign o_speed        = r_out_speed;
    assign o_limit        = r_limit;

endmodule

/* src/gain_scheduled_pid_steering.sv */
`timescale 1ns / 1ps
// An accepted request steps through MUL0, MUL1, MUL2, SUM, SCALE, DIV and FIN; FIN writes
//   the result to the output register once it is not full. The 12-step serial divider
//   for 7*turn / (10*P), three quotient bits per cycle, does most of the work.
// A new request is taken while the previous result still waits at the output.
// Reset (i_rst_n low, synchronous) clears turn and error history and loads the
//   default center reference, servo center and swing.

module gain_scheduled_pid_steering #(
    parameter int FRAC_BITS = gsps_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gsps_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [gsps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [14:0] line_distance, [17:15] position_band, [20:18] speed_band
    input  logic [gsps_pkg::TDATA_W-1:0]       s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [14:0] servo_position, [18:15] speed_command, [20:19] limit_hit
    output logic [gsps_pkg::TDATA_W-1:0]       m_axis_tdata
);

    localparam int DIST_W  = gsps_pkg::DIST_W;
    localparam int BAND_W  = gsps_pkg::BAND_W;
    localparam int FIELD_W = gsps_pkg::SERVO_W + gsps_pkg::SPEED_W + gsps_pkg::LIMIT_W;

    gsps_pkg::t_dp_cmd                 w_cmd;
    gsps_pkg::t_dp_sts                 w_sts;
    logic [gsps_pkg::SERVO_W-1:0]      w_servo;
    logic [gsps_pkg::SPEED_W-1:0]      w_speed;
    logic [gsps_pkg::LIMIT_W-1:0]      w_limit;

    gsps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    gsps_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_dist      ($signed(s_axis_tdata[DIST_W-1:0])),
        .i_pos       (s_axis_tdata[DIST_W +: BAND_W]),
        .i_spd       (s_axis_tdata[DIST_W+BAND_W +: BAND_W]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_servo     (w_servo),
        .o_speed     (w_speed),
        .o_limit     (w_limit)
    );

    assign m_axis_tdata = {{(gsps_pkg::TDATA_W-FIELD_W){1'b0}}, w_limit, w_speed, w_servo};

`ifndef ASSERT_OFF
    // one request at a time: the block is busy right after taking one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one still in work");

    // a fresh result only comes out of the finishing step, never from idle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without work in progress");

    a_limit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_limit == gsps_pkg::LIM_NONE || w_limit == gsps_pkg::LIM_HIGH
                           || w_limit == gsps_pkg::LIM_LOW))
        else $error("bad limit code on output");

    // finishing step only issues when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("pending result overwritten");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import gsps_pkg::*;

    localparam int     FRAC         = FRAC_BITS_DEF;
    localparam int     TURN_NUM     = 7;
    localparam int     TURN_DEN     = 10;
    localparam longint ERR_HI       = 131071;
    localparam longint ERR_LO       = -131072;
    localparam longint TURN_HI      = 64'sd2147483647;
    localparam longint TURN_LO      = -64'sd2147483648;
    localparam longint SERVO_TOP    = 32767;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     PHASE_ITEMS  = 140;

    // gain schedule, [position band][speed band]
    localparam int P_GAIN_TBL [5][5] = '{
        '{12, 10, 9, 10, 12},
        '{10, 9, 8, 9, 10},
        '{7, 7, 7, 7, 7},
        '{9, 7, 5, 7, 9},
        '{5, 4, 3, 4, 5}};
    localparam int D_GAIN_TBL [5][5] = '{
        '{2, 4, 7, 4, 2},
        '{4, 5, 6, 5, 4},
        '{6, 7, 8, 7, 6},
        '{9, 7, 8, 7, 9},
        '{12, 10, 9, 10, 12}};
    localparam int SPEED_TBL [5][5] = '{
        '{6, 7, 9, 7, 6},
        '{4, 6, 9, 6, 4},
        '{3, 5, 9, 5, 3},
        '{2, 4, 9, 4, 2},
        '{1, 3, 9, 3, 1}};

    typedef struct packed {
        logic [SERVO_W-1:0] servo;
        logic [SPEED_W-1:0] speed;
        logic [LIMIT_W-1:0] limit;
    } t_steer_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = CFG_CENTER_REF;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;

    gain_scheduled_pid_steering u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // controller state mirror
    logic signed [CREF_W-1:0] cref_q;
    logic [SERVO_W-1:0]       servo_center_q;
    logic [SWING_W-1:0]       swing_q;
    longint                   turn_q;
    longint                   err_last_q;
    longint                   err_prev_q;

    t_steer_result steer_expect_q[$];
    int mismatch_cnt  = 0;
    int accepted_cnt  = 0;
    int delivered_cnt = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int quiet_cycles  = 0;
    logic hold_req    = 1'b0;
    logic hold_ack    = 1'b0;
    int   hold_left   = 0;

    function automatic t_steer_result predict_steering(input logic [DIST_W-1:0] dist_bits,
                                                       input logic [BAND_W-1:0] pos_bits,
                                                       input logic [BAND_W-1:0] spd_bits);
        t_steer_result res;
        longint dist_val, err, incr, turn, p, d, center_val, hi_bound, lo_bound, servo;
        int pos, spd;
        pos = pos_bits;
        spd = spd_bits;
        if (pos > 4) pos = 4;
        if (spd > 4) spd = 4;
        p = P_GAIN_TBL[pos][spd];
        d = D_GAIN_TBL[pos][spd];

        dist_val = longint'($signed(dist_bits));
        err = longint'(cref_q) * (longint'(1) << FRAC) - dist_val;
        if (err > ERR_HI) err = ERR_HI;
        if (err < ERR_LO) err = ERR_LO;

        incr = (p + d) * err - (p + 2 * d) * err_last_q + d * err_prev_q;
        incr = incr / (longint'(1) << FRAC);
        turn = turn_q + incr;
        if (turn > TURN_HI) turn = TURN_HI;
        if (turn < TURN_LO) turn = TURN_LO;
        turn = (TURN_NUM * turn) / (p * TURN_DEN);

        turn_q     = turn;
        err_prev_q = err_last_q;
        err_last_q = err;

        center_val = servo_center_q;
        hi_bound   = center_val + swing_q;
        lo_bound   = center_val - swing_q;
        if (hi_bound > SERVO_TOP) hi_bound = SERVO_TOP;
        if (lo_bound < 0) lo_bound = 0;
        servo = center_val + turn;
        res.limit = LIM_NONE;
        if (servo > hi_bound) begin
            servo = hi_bound;
            res.limit = LIM_HIGH;
        end else if (servo < lo_bound) begin
            servo = lo_bound;
            res.limit = LIM_LOW;
        end
        res.servo = servo[SERVO_W-1:0];
        res.speed = SPEED_W'(SPEED_TBL[pos][spd]);
        return res;
    endfunction

    task automatic check_field(input string label, input longint expected, input longint actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, expected, actual);
            mismatch_cnt++;
        end
    endtask

    // mirror update, expectation store and result check
    always @(posedge i_clk) begin
        t_steer_result want;
        if (!i_rst_n) begin
            cref_q         = '0;
            servo_center_q = SERVO_CENTER_RST;
            swing_q        = SERVO_SWING_RST;
            turn_q         = 0;
            err_last_q     = 0;
            err_prev_q     = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                delivered_cnt++;
                if (steer_expect_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatch_cnt++;
                end else begin
                    want = steer_expect_q.pop_front();
                    check_field("servo_position", want.servo, m_axis_tdata[14:0]);
                    check_field("speed_command", want.speed, m_axis_tdata[18:15]);
                    check_field("limit_hit", want.limit, m_axis_tdata[20:19]);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CENTER_REF:   cref_q = i_cfg_data[CREF_W-1:0];
                    CFG_SERVO_CENTER: servo_center_q = i_cfg_data[SERVO_W-1:0];
                    CFG_SERVO_SWING:  swing_q = i_cfg_data[SWING_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                steer_expect_q.push_back(predict_steering(s_axis_tdata[14:0],
                                                          s_axis_tdata[17:15],
                                                          s_axis_tdata[20:18]));
        end
    end

    // output side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(input logic [DIST_W-1:0] dist_word, input logic [BAND_W-1:0] pos,
                             input logic [BAND_W-1:0] spd);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, spd, pos, dist_word};
        do @(posedge i_clk); while (!s_axis_tready);
        accepted_cnt++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (delivered_cnt != accepted_cnt) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] cref_word,
                               input logic [CFG_DATA_W-1:0] center_word,
                               input logic [CFG_DATA_W-1:0] swing_word);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_CENTER_REF;
        i_cfg_data <= cref_word;
        @(posedge i_clk);
        i_cfg_addr <= CFG_SERVO_CENTER;
        i_cfg_data <= center_word;
        @(posedge i_clk);
        i_cfg_addr <= CFG_SERVO_SWING;
        i_cfg_data <= swing_word;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_random_item();
        logic [DIST_W-1:0] dist_word;
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            dist_word = DIST_W'($urandom);
        else if (sel < 9)
            dist_word = DIST_W'($urandom_range(640) - 320);    // tracking close to the line
        else
            dist_word = $urandom_range(1) ? 15'h4000 : 15'h3FFF;
        send_item(dist_word, BAND_W'($urandom_range(7)), BAND_W'($urandom_range(7)));
    endtask

    // band sweep incl. saturating bands, distance extremes, reset config
    task automatic test_reset_defaults();
        logic [DIST_W-1:0] dists [8] = '{15'h4000, 15'h3FFF, 15'h0000, 15'h5555,
                                         15'h2AAA, 15'h7FFF, 15'h0001, 15'h6000};
        for (int i = 0; i < 8; i++)
            send_item(dists[i], BAND_W'(i), BAND_W'(7 - i));
    endtask

    // clamp bounds past the ends of the servo field, zero swing
    task automatic test_config_extremes();
        load_config(15'h03FF, 15'h7FFF, 15'h7FFF);
        send_item(15'h4000, 3'd0, 3'd0);
        send_item(15'h4000, 3'd2, 3'd2);
        send_item(15'h3FFF, 3'd4, 3'd4);
        load_config(15'h7C00, 15'h0000, 15'h0FFF);
        send_item(15'h3FFF, 3'd0, 3'd0);
        send_item(15'h3FFF, 3'd1, 3'd3);
        send_item(15'h4000, 3'd3, 3'd1);
        load_config(15'h0000, 15'd2870, 15'h0000);
        send_item(15'h0000, 3'd2, 3'd2);
        send_item(15'h0010, 3'd0, 3'd4);
        send_item(15'h7FF0, 3'd4, 3'd0);
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                       input logic [CFG_DATA_W-1:0] cref_word,
                                       input logic [CFG_DATA_W-1:0] center_word,
                                       input logic [CFG_DATA_W-1:0] swing_word);
        load_config(cref_word, center_word, swing_word);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_item();
    endtask

    // long output hold-off with the input kept busy
    task automatic test_output_backpressure();
        load_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        idle_pct  = 0;
        stall_pct = 0;
        hold_req <= ~hold_req;
        for (int i = 0; i < 40; i++)
            send_random_item();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_config_extremes();
        test_random_traffic(0, 0, 15'h0000, 15'd2870, 15'd725);
        test_random_traffic(66, 0, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                            CFG_DATA_W'($urandom));
        test_random_traffic(0, 66, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                            CFG_DATA_W'($urandom));
        test_random_traffic(29, 29, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                            CFG_DATA_W'($urandom_range(255)));
        test_output_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && steer_expect_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/gsps_pkg.sv
src/gsps_ctrl.sv
src/gsps_datapath.sv
src/gain_scheduled_pid_steering.sv
tb/testbench.sv
